// ===== hw/rtl/pit_pkg.sv =====
// Package for the periodic interrupt timer: request and response words,
// register and request codes, control bit positions and default sizes.
// No dependencies; used by pit_channel and periodic_interrupt_timer.
package pit_pkg;

  localparam int DefNumChannels = 4;
  localparam int DefCountWidth  = 32;
  localparam int DataWidth      = 32;
  localparam int IrqWidth       = 4;

  // Request type codes.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register select codes.
  localparam logic [2:0] REG_LOAD   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_CTRL   = 3'd2;
  localparam logic [2:0] REG_FLAG   = 3'd3;
  localparam logic [2:0] REG_MODULE = 3'd4;

  // Bit positions in the control and module control registers.
  localparam int CTL_EN      = 0;
  localparam int CTL_IE      = 1;
  localparam int CTL_CHAIN   = 2;
  localparam int CTL_WIDTH   = 3;
  localparam int MOD_DIS_BIT = 1;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [1:0]           channel;
    logic [2:0]           reg_select;
    logic [DataWidth-1:0] write_data;
  } pit_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic [IrqWidth-1:0]  irq_lines;
    logic [IrqWidth-1:0]  expired;
  } pit_rsp_t;

  // Per-channel strobes for the word being processed this cycle.
  typedef struct packed {
    logic                 tick;
    logic                 wr_load;
    logic                 wr_ctrl;
    logic                 wr_flag;
    logic [2:0]           sel;
    logic [DataWidth-1:0] wdata;
  } pit_chan_ctl_t;

endpackage

// ===== hw/rtl/pit_channel.sv =====
// One timer channel: load, count, control and flag registers, the
// down-count with reload, and the register read view.
// Depends on pit_pkg.
module pit_channel #(
  parameter int   COUNT_WIDTH = pit_pkg::DefCountWidth,
  parameter logic CHAINABLE   = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pit_pkg::pit_chan_ctl_t        ctl,
  input  logic                          below_fired,
  output logic                          fired,
  output logic                          irq_next,
  output logic [pit_pkg::DataWidth-1:0] rdata
);
  import pit_pkg::*;

  logic [COUNT_WIDTH-1:0] load_value, load_value_next;
  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic [CTL_WIDTH-1:0]   control, control_next;
  logic                   flag, flag_next;
  logic                   counts;

  always_comb begin
    counts = control[CTL_EN];
    if (CHAINABLE && control[CTL_CHAIN]) begin
      counts = control[CTL_EN] && below_fired;
    end
    fired = ctl.tick && counts && (count_value == '0);

    load_value_next  = load_value;
    count_value_next = count_value;
    control_next     = control;
    flag_next        = flag;

    if (ctl.wr_load) begin
      load_value_next = ctl.wdata[COUNT_WIDTH-1:0];
    end
    if (ctl.wr_ctrl) begin
      if (!control[CTL_EN] && ctl.wdata[CTL_EN]) begin
        count_value_next = load_value;
      end
      control_next = ctl.wdata[CTL_WIDTH-1:0];
    end
    if (ctl.wr_flag && ctl.wdata[0]) begin
      flag_next = 1'b0;
    end
    if (ctl.tick && counts) begin
      if (fired) begin
        count_value_next = load_value;
        flag_next        = 1'b1;
      end else begin
        count_value_next = count_value - COUNT_WIDTH'(1);
      end
    end
    irq_next = flag_next && control_next[CTL_IE];
  end

  always_comb begin
    case (ctl.sel)
      REG_LOAD:  rdata = DataWidth'(load_value);
      REG_COUNT: rdata = DataWidth'(count_value);
      REG_CTRL:  rdata = DataWidth'(control);
      REG_FLAG:  rdata = DataWidth'(flag);
      default:   rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value  <= '0;
      count_value <= '0;
      control     <= '0;
      flag        <= 1'b0;
    end else begin
      load_value  <= load_value_next;
      count_value <= count_value_next;
      control     <= control_next;
      flag        <= flag_next;
    end
  end

endmodule

// ===== hw/rtl/periodic_interrupt_timer.sv =====
// Top level of the periodic interrupt timer: input register, channel array,
// module control register and the response register.
// Depends on pit_pkg and pit_channel.
//
//   Channel   Handshake            Word
//   --------  -------------------  ----------------------------------------
//   req       req_valid/req_stall  pit_req_t: tick, register write or read
//   rsp       rsp_valid/rsp_stall  pit_rsp_t: read data, irq lines, expiry
//
// Each word is answered from the response register: while it sits in the
// input register, the channel update and the response are formed, and both
// are registered together when the word advances. A new word is taken
// every cycle while the response register drains. Reset clears all channel
// registers and leaves the module disabled. A stalled response holds the
// input register, which then stalls the request side.
module periodic_interrupt_timer #(
  parameter int NUM_CHANNELS = pit_pkg::DefNumChannels,
  parameter int COUNT_WIDTH  = pit_pkg::DefCountWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pit_pkg::pit_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pit_pkg::pit_rsp_t rsp
);
  import pit_pkg::*;

  // The input register holds the word being processed.
  logic     item_valid;
  pit_req_t item;
  logic     advance;

  // Module disable bit, set out of reset.
  logic module_disabled;

  logic [NUM_CHANNELS-1:0] fired;
  logic [NUM_CHANNELS-1:0] irq_next;
  logic [DataWidth-1:0]    chan_rdata [NUM_CHANNELS];
  pit_chan_ctl_t           chan_ctl   [NUM_CHANNELS];

  logic           is_tick, is_write, is_read;
  pit_rsp_t       rsp_next;
  logic [DataWidth-1:0] rd_chan;

  // The word advances whenever the response register is free or draining.
  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;

  assign is_tick  = advance && (item.req_type == REQ_TICK) && !module_disabled;
  assign is_write = advance && (item.req_type == REQ_WRITE);
  assign is_read  = (item.req_type == REQ_READ);

  // Channel n counts on a tick when enabled; a chained channel also needs the
  // channel below it to have expired on the same tick. Channel zero ignores chain.
  for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_chan
    logic hit;
    assign hit = (int'(item.channel) == n);

    always_comb begin
      chan_ctl[n].tick    = is_tick;
      chan_ctl[n].wr_load = is_write && hit && (item.reg_select == REG_LOAD);
      chan_ctl[n].wr_ctrl = is_write && hit && (item.reg_select == REG_CTRL);
      chan_ctl[n].wr_flag = is_write && hit && (item.reg_select == REG_FLAG);
      chan_ctl[n].sel     = item.reg_select;
      chan_ctl[n].wdata   = item.write_data;
    end

    if (n == 0) begin : g_first
      pit_channel #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .CHAINABLE  (1'b0)
      ) u_chan (
        .clk        (clk),
        .rst        (rst),
        .ctl        (chan_ctl[n]),
        .below_fired(1'b0),
        .fired      (fired[n]),
        .irq_next   (irq_next[n]),
        .rdata      (chan_rdata[n])
      );
    end else begin : g_rest
      pit_channel #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .CHAINABLE  (1'b1)
      ) u_chan (
        .clk        (clk),
        .rst        (rst),
        .ctl        (chan_ctl[n]),
        .below_fired(fired[n-1]),
        .fired      (fired[n]),
        .irq_next   (irq_next[n]),
        .rdata      (chan_rdata[n])
      );
    end
  end

  // Response forming. Reads see the state before this word; the interrupt
  // lines show the state after it. Channels above the fourth are not shown.
  always_comb begin
    rd_chan = '0;
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      if (int'(item.channel) == n) begin
        rd_chan = chan_rdata[n];
      end
    end

    rsp_next = '0;
    if (is_read) begin
      if (item.reg_select == REG_MODULE) begin
        rsp_next.read_data[MOD_DIS_BIT] = module_disabled;
      end else begin
        rsp_next.read_data = rd_chan;
      end
    end
    for (int n = 0; n < NUM_CHANNELS && n < IrqWidth; n++) begin
      rsp_next.irq_lines[n] = irq_next[n];
      rsp_next.expired[n]   = fired[n] && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid      <= 1'b0;
      rsp_valid       <= 1'b0;
      module_disabled <= 1'b1;
    end else begin
      if (!item_valid || advance) begin
        item_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (is_write && (item.reg_select == REG_MODULE)) begin
        module_disabled <= item.write_data[MOD_DIS_BIT];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && (!item_valid || advance)) begin
      item <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule
